[rtl/pmd_pkg.sv]
// Shared widths, limits and handshake structs for the offset mean / peak deviation block.
package pmd_pkg;

    // Field widths fixed by the interface
    localparam int IN_W      = 32;
    localparam int MEAN_W    = 40;
    localparam int DEV_W     = 41;
    localparam int SEEN_W    = 32;

    // Arithmetic configuration
    localparam int FRAC_BITS   = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int SUM_W       = 64;

    // Derived widths
    localparam int DVD_W  = SUM_W + FRAC_BITS;
    localparam int ITER_W = $clog2(DVD_W);
    localparam int SQ_W   = IN_W + FRAC_BITS;
    localparam int DIFF_W = ((SQ_W > MEAN_W) ? SQ_W : MEAN_W) + 1;
    localparam int CMP_W  = (DIFF_W > DEV_W) ? DIFF_W : DEV_W;

    // Limits
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [SUM_W-1:0]       MEAN_LIM  = SUM_W'(1) << (MEAN_W - 1);
    localparam logic [MEAN_W-1:0]      MEAN_MAX  = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0]      MEAN_MIN  = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic [DEV_W-1:0]       DEV_MAX   = {DEV_W{1'b1}};

    // Divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/pmd_serial_div.sv]
// Bit-serial restoring divider: (dividend << FRAC_BITS) / divisor, one quotient bit per cycle.
module pmd_serial_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pmd_pkg::t_div_ctl                   i_ctl,
    input  logic [pmd_pkg::SUM_W-1:0]           i_dividend,
    input  logic [pmd_pkg::COUNT_WIDTH-1:0]     i_divisor,
    output pmd_pkg::t_div_stat                  o_stat,
    output logic [pmd_pkg::SUM_W-1:0]           o_quotient
);

    logic [pmd_pkg::DVD_W-1:0]         r_dvd;
    logic [pmd_pkg::COUNT_WIDTH-1:0]   r_rem;
    logic [pmd_pkg::SUM_W-1:0]         r_quo;
    logic [pmd_pkg::ITER_W-1:0]        r_iter;
    logic                              r_busy;
    logic                              r_done;

    logic [pmd_pkg::COUNT_WIDTH:0]     rem_sh;
    logic [pmd_pkg::COUNT_WIDTH:0]     trial;
    logic                              qbit;
    logic [pmd_pkg::COUNT_WIDTH-1:0]   n_rem;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        rem_sh = {r_rem, r_dvd[pmd_pkg::DVD_W-1]};
        trial  = rem_sh - {1'b0, i_divisor};
        qbit   = ~trial[pmd_pkg::COUNT_WIDTH];
        n_rem  = qbit ? trial[pmd_pkg::COUNT_WIDTH-1:0] : rem_sh[pmd_pkg::COUNT_WIDTH-1:0];
    end

    // Step the iteration; quotient bits above SUM_W drop off the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_iter <= pmd_pkg::ITER_W'(pmd_pkg::DVD_W - 1);
                r_dvd  <= pmd_pkg::DVD_W'(i_dividend) << pmd_pkg::FRAC_BITS;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_dvd <= r_dvd << 1;
                r_rem <= n_rem;
                r_quo <= {r_quo[pmd_pkg::SUM_W-2:0], qbit};
                if (r_iter == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_iter <= r_iter - 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[rtl/pps_offset_mean_peak_deviation_core.sv]
// Top level: running mean of PPS offsets and peak deviation from it.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  input    | in        | i_valid / o_stall  | i_offset_ticks
//  result   | out       | o_valid / i_stall  | o_mean_q8, o_deviation_q8,
//           |           |                    | o_peak_deviation_q8, o_samples_seen, o_saturated
//
// One sample runs from acceptance (sum updated at the accepting edge) through S_PREP, which
// starts the divider on the sum magnitude, S_DIV, where the bit-serial divider gives one quotient
// bit per cycle over the 72-bit scaled dividend until it finishes, then S_MEAN, S_DIFF and S_OUT.
// Samples enter only while the sequencer is idle; a result waits in the output register, so the
// next sample may enter while it is stalled, and a stall still pending holds the last step.
// Reset (synchronous, active low) clears count, sum, peak, the sequencer and the output valid.
module pps_offset_mean_peak_deviation_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [pmd_pkg::IN_W-1:0]  i_offset_ticks,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [pmd_pkg::MEAN_W-1:0] o_mean_q8,
    output logic [pmd_pkg::DEV_W-1:0]        o_deviation_q8,
    output logic [pmd_pkg::DEV_W-1:0]        o_peak_deviation_q8,
    output logic [pmd_pkg::SEEN_W-1:0]       o_samples_seen,
    output logic                             o_saturated
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MEAN,
        S_DIFF,
        S_OUT
    } t_state;

    t_state                                 r_state;
    logic [pmd_pkg::COUNT_WIDTH-1:0]        r_count;
    logic [pmd_pkg::SUM_W-1:0]              r_sum;
    logic [pmd_pkg::DEV_W-1:0]              r_peak;
    logic signed [pmd_pkg::IN_W-1:0]        r_sample;
    logic                                   r_sat;
    logic                                   r_neg;
    logic signed [pmd_pkg::MEAN_W-1:0]      r_mean;
    logic signed [pmd_pkg::DIFF_W-1:0]      r_diff;
    logic                                   r_out_valid;

    logic                                   in_take;
    logic                                   out_free;
    logic                                   n_sat;
    logic [pmd_pkg::SUM_W-1:0]              n_sum;
    logic [pmd_pkg::SUM_W-1:0]              sum_mag;
    logic [pmd_pkg::SUM_W-1:0]              quo;
    logic [pmd_pkg::MEAN_W-1:0]             n_mean;
    logic signed [pmd_pkg::DIFF_W-1:0]      sample_q;
    logic signed [pmd_pkg::DIFF_W-1:0]      n_diff;
    logic [pmd_pkg::DIFF_W-1:0]             diff_abs;
    logic [pmd_pkg::DEV_W-1:0]              n_dev;
    logic [pmd_pkg::DEV_W-1:0]              n_peak;

    pmd_pkg::t_div_ctl                      div_ctl;
    pmd_pkg::t_div_stat                     div_stat;

    // Handshake
    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // Accumulate unless the count is pinned at its limit
    always_comb begin
        n_sat = (r_count == pmd_pkg::COUNT_MAX);
        n_sum = r_sum + pmd_pkg::SUM_W'(i_offset_ticks);
    end

    // Magnitude of the sum feeds the divider
    assign sum_mag       = r_sum[pmd_pkg::SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign div_ctl.start = (r_state == S_PREP);

    pmd_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (sum_mag),
        .i_divisor  (r_count),
        .o_stat     (div_stat),
        .o_quotient (quo)
    );

    // Restore the sign and clamp to the mean range
    always_comb begin
        if (r_neg) begin
            n_mean = (quo > pmd_pkg::MEAN_LIM) ? pmd_pkg::MEAN_MIN
                                                : (~quo[pmd_pkg::MEAN_W-1:0] + 1'b1);
        end else begin
            n_mean = (quo >= pmd_pkg::MEAN_LIM) ? pmd_pkg::MEAN_MAX
                                                 : quo[pmd_pkg::MEAN_W-1:0];
        end
    end

    // Difference of the scaled sample and the mean
    always_comb begin
        sample_q = pmd_pkg::DIFF_W'(r_sample) <<< pmd_pkg::FRAC_BITS;
        n_diff   = sample_q - pmd_pkg::DIFF_W'(r_mean);
    end

    // Absolute deviation with clamp, then peak
    always_comb begin
        diff_abs = r_diff[pmd_pkg::DIFF_W-1] ? (~r_diff + 1'b1) : r_diff;
        if (pmd_pkg::CMP_W'(diff_abs) > pmd_pkg::CMP_W'(pmd_pkg::DEV_MAX)) begin
            n_dev = pmd_pkg::DEV_MAX;
        end else begin
            n_dev = pmd_pkg::DEV_W'(diff_abs);
        end
        n_peak = (n_dev > r_peak) ? n_dev : r_peak;
    end

    // Sequence one sample and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output valid once the receiver takes the transaction
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_sample <= i_offset_ticks;
                        r_sat    <= n_sat;
                        if (!n_sat) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= n_sum;
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_neg   <= r_sum[pmd_pkg::SUM_W-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    r_mean  <= n_mean;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= n_diff;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_peak              <= n_peak;
                        o_mean_q8           <= r_mean;
                        o_deviation_q8      <= n_dev;
                        o_peak_deviation_q8 <= n_peak;
                        o_samples_seen      <= pmd_pkg::SEEN_W'(r_count);
                        o_saturated         <= r_sat;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;

    // Divider runs only while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    // Sample count never moves backward
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("sample count decreased");

    // Peak covers the deviation it is reported with
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_peak_deviation_q8 >= o_deviation_q8))
        else $error("peak below current deviation");

    // A saturated result carries the pinned count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_samples_seen == pmd_pkg::SEEN_W'(pmd_pkg::COUNT_MAX)))
        else $error("saturated flag without full count");

endmodule

[sim/tb_pps_offset_mean_peak_deviation_core.sv]
// Self-checking testbench for the PPS offset running mean / peak deviation core.
`timescale 1ns / 100ps

module tb_pps_offset_mean_peak_deviation_core;
    import pmd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int QUIET_TAIL  = 150;
    localparam int RANDOM_ITEMS = 1300;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic signed [IN_W-1:0] offset;
        bit                     wait_drain;
    } offset_item_t;

    typedef struct {
        logic signed [MEAN_W-1:0] mean;
        logic [DEV_W-1:0]         dev;
        logic [DEV_W-1:0]         peak;
        logic [SEEN_W-1:0]        seen;
        logic                     sat;
    } offset_stats_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [IN_W-1:0]   i_offset_ticks = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [MEAN_W-1:0] o_mean_q8;
    logic [DEV_W-1:0]         o_deviation_q8;
    logic [DEV_W-1:0]         o_peak_deviation_q8;
    logic [SEEN_W-1:0]        o_samples_seen;
    logic                     o_saturated;

    offset_item_t  offsets_to_send[$];
    offset_stats_t stats_due[$];

    // Shadow of the block's accumulators
    logic [COUNT_WIDTH-1:0] acc_count;
    logic [SUM_W-1:0]       acc_sum;
    logic [DEV_W-1:0]       acc_peak;

    int mismatches   = 0;
    int accepted_cnt = 0;
    int total_items  = 0;
    int cycle_cnt    = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    bit quiet_tail;

    assign quiet_tail = (accepted_cnt + QUIET_TAIL >= total_items);

    pps_offset_mean_peak_deviation_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_offset_ticks      (i_offset_ticks),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_mean_q8           (o_mean_q8),
        .o_deviation_q8      (o_deviation_q8),
        .o_peak_deviation_q8 (o_peak_deviation_q8),
        .o_samples_seen      (o_samples_seen),
        .o_saturated         (o_saturated)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Accumulate one sample and queue the result it must produce.
    // The count limit cannot be reached with 32-bit counts in a run this short,
    // and with 8 fraction bits neither the mean nor the deviation can clip,
    // but the clamps are kept so the shadow follows the block in every case.
    task automatic accumulate_offset(input logic signed [IN_W-1:0] off);
        offset_stats_t    r;
        logic [DVD_W-1:0] quot;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] quo;
        logic [SUM_W-1:0] mean64;
        logic [SUM_W-1:0] sample_q;
        logic [SUM_W-1:0] diff;
        logic [SUM_W-1:0] dev64;
        logic             frozen;
        logic             neg;
        frozen = (acc_count >= COUNT_MAX);
        if (!frozen) begin
            acc_count = acc_count + 1'b1;
            acc_sum   = acc_sum + {{(SUM_W-IN_W){off[IN_W-1]}}, off};
        end
        neg  = acc_sum[SUM_W-1];
        mag  = neg ? (SUM_W'(0) - acc_sum) : acc_sum;
        quot = {mag, {FRAC_BITS{1'b0}}} / DVD_W'(acc_count);
        quo  = quot[SUM_W-1:0];
        // Clamp the mean to the signed 40-bit range
        if (neg)
            mean64 = (quo > MEAN_LIM) ? (SUM_W'(0) - MEAN_LIM) : (SUM_W'(0) - quo);
        else
            mean64 = (quo >= MEAN_LIM) ? (MEAN_LIM - 1'b1) : quo;
        sample_q = {{(SUM_W-IN_W-FRAC_BITS){off[IN_W-1]}}, off, {FRAC_BITS{1'b0}}};
        diff  = sample_q - mean64;
        dev64 = diff[SUM_W-1] ? (SUM_W'(0) - diff) : diff;
        if (dev64 > SUM_W'(DEV_MAX))
            dev64 = SUM_W'(DEV_MAX);
        if (dev64[DEV_W-1:0] > acc_peak)
            acc_peak = dev64[DEV_W-1:0];
        r.mean = mean64[MEAN_W-1:0];
        r.dev  = dev64[DEV_W-1:0];
        r.peak = acc_peak;
        r.seen = SEEN_W'(acc_count);
        r.sat  = frozen;
        stats_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_offset(input logic signed [IN_W-1:0] off, input bit drain);
        offset_item_t it;
        it.offset     = off;
        it.wait_drain = drain;
        offsets_to_send.push_back(it);
    endtask

    // Sample driver: predict on every accepted transaction, then pick the next one
    always @(posedge i_clk) begin : sample_driver
        logic nxt_valid;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            acc_count = '0;
            acc_sum   = '0;
            acc_peak  = '0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && !o_stall) begin
                accumulate_offset(i_offset_ticks);
                accepted_cnt++;
            end
            // Slot is free: hold off, wait for the pipeline to drain, or advance
            if (!i_valid || !o_stall) begin
                nxt_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (offsets_to_send.size() == 0) begin
                    nxt_valid = 1'b0;
                end else if (offsets_to_send[0].wait_drain && stats_due.size() != 0) begin
                    nxt_valid = 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 99) < 8) begin
                    send_gap = $urandom_range(1, 18) - 1;
                end else begin
                    nxt_valid = 1'b1;
                    i_offset_ticks <= offsets_to_send.pop_front().offset;
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge i_clk) begin : result_monitor
        offset_stats_t want;
        logic          nxt_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (stats_due.size() == 0) begin
                    $display("%0t: result with none expected, mean 0x%0h", $time, o_mean_q8);
                    mismatches++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("mean_q8", 64'(want.mean[MEAN_W-1:0]),
                                64'(o_mean_q8[MEAN_W-1:0]));
                    check_field("deviation_q8", 64'(want.dev), 64'(o_deviation_q8));
                    check_field("peak_deviation_q8", 64'(want.peak),
                                64'(o_peak_deviation_q8));
                    check_field("samples_seen", 64'(want.seen), 64'(o_samples_seen));
                    check_field("saturated", 64'(want.sat), 64'(o_saturated));
                end
            end
            // Stall in random bursts, none in the tail
            nxt_stall = 1'b0;
            if (stall_left > 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 99) < 6) begin
                stall_left = $urandom_range(1, 18) - 1;
                nxt_stall  = 1'b1;
            end
            i_stall <= nxt_stall;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Build the stimulus, release reset, and wait for the run to finish
    initial begin : stimulus
        int                     center;
        logic signed [IN_W-1:0] v;
        // Directed: extremes, sign changes, truncation of negative means
        queue_offset(32'sd0, 1'b0);
        queue_offset(32'sd1, 1'b0);
        queue_offset(-32'sd1, 1'b0);
        queue_offset(32'h7FFF_FFFF, 1'b0);
        queue_offset(32'h8000_0000, 1'b0);
        queue_offset(32'h7FFF_FFFF, 1'b0);
        queue_offset(32'h7FFF_FFFF, 1'b0);
        queue_offset(32'h8000_0000, 1'b0);
        queue_offset(32'h8000_0000, 1'b0);
        queue_offset(32'h8000_0000, 1'b0);
        queue_offset(32'sd0, 1'b1);
        queue_offset(32'h5555_5555, 1'b0);
        queue_offset(32'hAAAA_AAAA, 1'b0);
        queue_offset(32'sd100, 1'b0);
        queue_offset(-32'sd100, 1'b0);
        queue_offset(32'sd3, 1'b0);
        queue_offset(-32'sd3, 1'b0);
        queue_offset(32'sd7, 1'b0);
        queue_offset(32'h0000_0100, 1'b0);
        queue_offset(32'hFFFF_FF00, 1'b0);

        // Random: wide values, a jittering offset around a center, extremes and small offsets
        center = $urandom_range(0, 4000) - 2000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = $urandom;
                4, 5, 6:    v = center + $urandom_range(0, 64) - 32;
                7: begin
                    case ($urandom_range(0, 4))
                        0:       v = 32'h7FFF_FFFF;
                        1:       v = 32'h8000_0000;
                        2:       v = 32'sd0;
                        3:       v = -32'sd1;
                        default: v = 32'sd1;
                    endcase
                end
                8:       v = $urandom_range(0, 511) - 256;
                default: v = {($urandom_range(0, 1) ? 2'b01 : 2'b10), 30'($urandom)};
            endcase
            queue_offset(v, (n == 400) || (n == 900));
        end
        total_items = offsets_to_send.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (offsets_to_send.size() != 0 || i_valid) @(posedge i_clk);
        while (stats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && stats_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
